### rtl/core/atl_pkg.sv
package atl_pkg;

  // Inputs are prescaled by 2^PRESCALE before the CORDIC starts
  localparam int PRESCALE = 24;

  // Digit width of the serial CORDIC datapath
  localparam int DIGIT_W = 16;

  // Arctangent table: atan(2^-i) in centidegrees Q16, rounded
  localparam int TABLE_LEN  = 24;
  localparam int ITER_IDX_W = 5;
  localparam int ATAN_W     = 29;

  localparam logic [ATAN_W-1:0] ATAN_CDEG_Q16 [TABLE_LEN] = '{
    29'd294912000, 29'd174096719, 29'd91987925, 29'd46694507,
    29'd23437865,  29'd11730358,  29'd5866610,  29'd2933484,
    29'd1466764,   29'd733385,    29'd366693,   29'd183346,
    29'd91673,     29'd45837,     29'd22918,    29'd11459,
    29'd5730,      29'd2865,      29'd1432,     29'd716,
    29'd358,       29'd179,       29'd90,       29'd45
  };

  // Angle accumulator and target widths
  localparam int Z_W   = 31;
  localparam int TGT_W = 32;

  // +-180 degrees in centidegrees Q16
  localparam logic signed [TGT_W-1:0] LIMIT_Q16 = 32'sd1179648000;

  // Smoothing weight register
  localparam int              ALPHA_W     = 17;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 17'd65536;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd3277;

  // Kept angle and output widths
  localparam int KEPT_W = 32;
  localparam int TILT_W = 16;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
  } atl_in_t;

  typedef struct packed {
    logic signed [TILT_W-1:0] tilt_x;
    logic signed [TILT_W-1:0] tilt_z;
  } atl_out_t;

  // Sequencer controls for one CORDIC lane
  typedef struct packed {
    logic                  load;
    logic                  step;
    logic                  first;
    logic                  last;
    logic                  fin;
    logic [ITER_IDX_W-1:0] iter;
  } atl_lane_ctl_t;

  // Sequencer controls for one smoothing unit
  typedef struct packed {
    logic diff;
    logic mul;
    logic upd;
  } atl_blend_ctl_t;

endpackage

### rtl/core/atl_cordic.sv
module atl_cordic #(
  parameter int ONE_G_COUNTS = 4096,
  parameter int SAMPLE_WIDTH = 16,
  parameter int WORD_W       = 48
) (
  input  logic                                 clk_i,
  input  atl_pkg::atl_lane_ctl_t               ctl_i,
  input  logic                                 neg_i,
  input  logic signed [SAMPLE_WIDTH-1:0]       sample_i,
  output logic signed [atl_pkg::TGT_W-1:0]     target_o
);

  localparam int D  = atl_pkg::DIGIT_W;
  localparam int ZW = atl_pkg::Z_W;

  localparam logic [WORD_W-1:0] X_INIT = WORD_W'(ONE_G_COUNTS) << atl_pkg::PRESCALE;

  // Operand words shift right one digit a cycle while stepping; result words collect new digits
  logic [WORD_W-1:0] ox_q, ox_d, oy_q, oy_d;
  logic [WORD_W-1:0] rx_q, rx_d, ry_q, ry_d;
  logic              cx_q, cy_q;
  logic signed [ZW-1:0] z_q, z_d;
  logic signed [atl_pkg::TGT_W-1:0] tgt_q, tgt_d;

  logic          y_neg;
  logic [D-1:0]  dx_dig, dy_dig;
  logic          cin_x, cin_y;
  logic [D:0]    sum_x, sum_y;
  logic [ZW-1:0] tab_val;
  logic signed [atl_pkg::TGT_W-1:0] dbl, clamped;
  logic [WORD_W-1:0] y_init;

  assign y_init = WORD_W'(sample_i) << atl_pkg::PRESCALE;

  // Direction follows the sign of y, which arithmetic shifts keep in the top bit
  assign y_neg  = oy_q[WORD_W-1];
  assign dx_dig = oy_q[ctl_i.iter +: D];
  assign dy_dig = ox_q[ctl_i.iter +: D];
  assign cin_x  = ctl_i.first ? y_neg  : cx_q;
  assign cin_y  = ctl_i.first ? ~y_neg : cy_q;

  // Add or subtract one digit, carry kept for the next digit
  assign sum_x = {1'b0, ox_q[D-1:0]} + {1'b0, (y_neg ? ~dx_dig : dx_dig)} + (D+1)'(cin_x);
  assign sum_y = {1'b0, oy_q[D-1:0]} + {1'b0, (y_neg ? dy_dig : ~dy_dig)} + (D+1)'(cin_y);

  assign rx_d = {sum_x[D-1:0], rx_q[WORD_W-1:D]};
  assign ry_d = {sum_y[D-1:0], ry_q[WORD_W-1:D]};

  // Advance operands by one digit, or take the finished words on the last digit
  assign ox_d = ctl_i.last ? rx_d : {{D{ox_q[WORD_W-1]}}, ox_q[WORD_W-1:D]};
  assign oy_d = ctl_i.last ? ry_d : {{D{oy_q[WORD_W-1]}}, oy_q[WORD_W-1:D]};

  // Accumulate the angle once per iteration
  assign tab_val = ZW'(atl_pkg::ATAN_CDEG_Q16[ctl_i.iter]);
  assign z_d     = y_neg ? (z_q - $signed(tab_val)) : (z_q + $signed(tab_val));

  // Double, clamp to +-180 degrees, negate where asked
  assign dbl = {z_q, 1'b0};
  always_comb begin
    clamped = dbl;
    if (dbl > atl_pkg::LIMIT_Q16) begin
      clamped = atl_pkg::LIMIT_Q16;
    end else if (dbl < -atl_pkg::LIMIT_Q16) begin
      clamped = -atl_pkg::LIMIT_Q16;
    end
    tgt_d = neg_i ? -clamped : clamped;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      ox_q <= X_INIT;
      oy_q <= y_init;
      z_q  <= '0;
    end else if (ctl_i.step) begin
      ox_q <= ox_d;
      oy_q <= oy_d;
      rx_q <= rx_d;
      ry_q <= ry_d;
      cx_q <= sum_x[D];
      cy_q <= sum_y[D];
      if (ctl_i.last) begin
        z_q <= z_d;
      end
    end
    if (ctl_i.fin) begin
      tgt_q <= tgt_d;
    end
  end

  assign target_o = tgt_q;

endmodule

### rtl/core/atl_blend.sv
module atl_blend (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  atl_pkg::atl_blend_ctl_t              ctl_i,
  input  logic signed [atl_pkg::TGT_W-1:0]     target_i,
  input  logic [atl_pkg::ALPHA_W-1:0]          alpha_i,
  output logic signed [atl_pkg::TILT_W-1:0]    tilt_o
);

  localparam int KW   = atl_pkg::KEPT_W;
  localparam int DW   = KW + 1;
  localparam int PW   = DW + atl_pkg::ALPHA_W + 1;

  logic signed [KW-1:0] kept_q;
  logic signed [DW-1:0] diff_q, diff_d;
  logic signed [PW-1:0] prod_q, prod_d;
  logic [atl_pkg::ALPHA_W-1:0] alpha_c;
  logic [atl_pkg::TILT_W-1:0]  hi;
  logic                        round_up;

  // Weights above one act as one
  assign alpha_c = alpha_i[atl_pkg::ALPHA_W-1] ? atl_pkg::ALPHA_ONE : alpha_i;

  assign diff_d = DW'(target_i) - DW'(kept_q);
  assign prod_d = PW'(diff_q) * PW'($signed({1'b0, alpha_c}));

  // Keep the smoothed angle; step by floor(diff * alpha / 2^16)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kept_q <= '0;
    end else if (ctl_i.upd) begin
      kept_q <= kept_q + prod_q[KW+15:16];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.diff) begin
      diff_q <= diff_d;
    end
    if (ctl_i.mul) begin
      prod_q <= prod_d;
    end
  end

  // Convert to whole centidegrees, truncating toward zero
  assign hi       = kept_q[KW-1:16];
  assign round_up = kept_q[KW-1] & (|kept_q[15:0]);
  assign tilt_o   = hi + atl_pkg::TILT_W'(round_up);

endmodule

### rtl/core/accel_tilt_lowpass_core.sv
// After input accept the digit-serial CORDIC lanes run ITERS iterations of
//   DIGITS digits (16 iterations of 3 by default), one 16-bit digit of each
//   word per cycle in S_CORDIC; then S_FIN, S_DIFF, S_MUL, S_UPD and S_OUT,
//   and a new item is accepted only after the result is loaded.
// Reset: both smoothed angles clear to zero and the weight returns to 3277.
module accel_tilt_lowpass_core #(
  parameter int ONE_G_COUNTS    = 4096,
  parameter int SAMPLE_WIDTH    = 16,
  parameter int ATAN_ITERATIONS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  atl_pkg::atl_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output atl_pkg::atl_out_t             out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [atl_pkg::ALPHA_W-1:0]   cfg_data_i
);

  localparam int ITERS    = (ATAN_ITERATIONS > atl_pkg::TABLE_LEN) ?
                            atl_pkg::TABLE_LEN : ATAN_ITERATIONS;
  localparam int G_BITS   = $clog2(ONE_G_COUNTS + 1);
  localparam int MAG_BITS = ((SAMPLE_WIDTH - 1 > G_BITS) ? SAMPLE_WIDTH - 1 : G_BITS) +
                            atl_pkg::PRESCALE;
  localparam int WORD_MIN = (MAG_BITS + 3 > atl_pkg::PRESCALE + atl_pkg::DIGIT_W) ?
                            MAG_BITS + 3 : atl_pkg::PRESCALE + atl_pkg::DIGIT_W;
  localparam int DIGITS   = (WORD_MIN + atl_pkg::DIGIT_W - 1) / atl_pkg::DIGIT_W;
  localparam int WORD_W   = DIGITS * atl_pkg::DIGIT_W;
  localparam int DIG_W    = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int IT_W     = (ITERS > 1) ? $clog2(ITERS) : 1;
  localparam int RAW_W    = (SAMPLE_WIDTH > 16) ? SAMPLE_WIDTH : 16;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CORDIC = 3'd1;
  localparam logic [2:0] S_FIN    = 3'd2;
  localparam logic [2:0] S_DIFF   = 3'd3;
  localparam logic [2:0] S_MUL    = 3'd4;
  localparam logic [2:0] S_UPD    = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  logic [2:0]       state_q, state_d;
  logic [DIG_W-1:0] dig_q, dig_d;
  logic [IT_W-1:0]  itr_q, itr_d;
  logic [atl_pkg::ALPHA_W-1:0] alpha_q;
  logic             out_valid_q, out_valid_d;
  atl_pkg::atl_out_t out_q;

  logic in_take, out_load, dig_last, itr_last;
  logic [RAW_W-1:0] raw_x, raw_y;
  logic signed [SAMPLE_WIDTH-1:0] smp_x, smp_y;
  logic signed [atl_pkg::TGT_W-1:0] tgt_x, tgt_z;
  logic signed [atl_pkg::TILT_W-1:0] tilt_x, tilt_z;

  atl_pkg::atl_lane_ctl_t  lane_ctl;
  atl_pkg::atl_blend_ctl_t blend_ctl;

  // Take the low sample bits of each field as two's complement
  assign raw_x = RAW_W'($unsigned(in_data_i.accel_x));
  assign raw_y = RAW_W'($unsigned(in_data_i.accel_y));
  assign smp_x = $signed(raw_x[SAMPLE_WIDTH-1:0]);
  assign smp_y = $signed(raw_y[SAMPLE_WIDTH-1:0]);

  assign in_stall_o = (state_q != S_IDLE);
  assign in_take    = in_valid_i && (state_q == S_IDLE);
  assign dig_last   = (dig_q == DIG_W'(DIGITS - 1));
  assign itr_last   = (itr_q == IT_W'(ITERS - 1));
  assign out_load   = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);

  // Drive the lanes and smoothing units from the sequencer
  always_comb begin
    lane_ctl.load  = in_take;
    lane_ctl.step  = (state_q == S_CORDIC);
    lane_ctl.first = (dig_q == '0);
    lane_ctl.last  = dig_last;
    lane_ctl.fin   = (state_q == S_FIN);
    lane_ctl.iter  = atl_pkg::ITER_IDX_W'(itr_q);
    blend_ctl.diff = (state_q == S_DIFF);
    blend_ctl.mul  = (state_q == S_MUL);
    blend_ctl.upd  = (state_q == S_UPD);
  end

  // Sequence digits within iterations, then the smoothing steps
  always_comb begin
    state_d = state_q;
    dig_d   = dig_q;
    itr_d   = itr_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_CORDIC;
          dig_d   = '0;
          itr_d   = '0;
        end
      end
      S_CORDIC: begin
        if (dig_last) begin
          dig_d = '0;
          if (itr_last) begin
            state_d = S_FIN;
          end else begin
            itr_d = itr_q + 1'b1;
          end
        end else begin
          dig_d = dig_q + 1'b1;
        end
      end
      S_FIN:  state_d = S_DIFF;
      S_DIFF: state_d = S_MUL;
      S_MUL:  state_d = S_UPD;
      S_UPD:  state_d = S_OUT;
      S_OUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold the result item until taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      dig_q       <= '0;
      itr_q       <= '0;
      out_valid_q <= 1'b0;
      alpha_q     <= atl_pkg::ALPHA_RESET;
    end else begin
      state_q     <= state_d;
      dig_q       <= dig_d;
      itr_q       <= itr_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        alpha_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.tilt_x <= tilt_x;
      out_q.tilt_z <= tilt_z;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // First axis lane and smoothing
  atl_cordic #(
    .ONE_G_COUNTS (ONE_G_COUNTS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .WORD_W       (WORD_W)
  ) u_lane_x (
    .clk_i    (clk_i),
    .ctl_i    (lane_ctl),
    .neg_i    (1'b0),
    .sample_i (smp_x),
    .target_o (tgt_x)
  );

  atl_blend u_blend_x (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (blend_ctl),
    .target_i (tgt_x),
    .alpha_i  (alpha_q),
    .tilt_o   (tilt_x)
  );

  // Second axis lane, negated, and smoothing
  atl_cordic #(
    .ONE_G_COUNTS (ONE_G_COUNTS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .WORD_W       (WORD_W)
  ) u_lane_z (
    .clk_i    (clk_i),
    .ctl_i    (lane_ctl),
    .neg_i    (1'b1),
    .sample_i (smp_y),
    .target_o (tgt_z)
  );

  atl_blend u_blend_z (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (blend_ctl),
    .target_i (tgt_z),
    .alpha_i  (alpha_q),
    .tilt_o   (tilt_z)
  );

endmodule

### test/accel_tilt_lowpass_core_test.sv
`timescale 1ns / 1ps

module accel_tilt_lowpass_core_test;

  localparam int ONE_G_COUNTS    = 4096;
  localparam int SAMPLE_WIDTH    = 16;
  localparam int ATAN_ITERATIONS = 16;
  localparam int ATAN_STEPS_MAX  = 24;
  localparam int ANGLE_PRESCALE  = 24;
  localparam longint TILT_LIMIT  = 64'sd18000 * 64'sd65536;
  localparam logic [atl_pkg::ALPHA_W-1:0] WEIGHT_AT_RESET = 17'd3277;
  localparam logic [atl_pkg::ALPHA_W-1:0] WEIGHT_FULL     = 17'd65536;
  localparam logic [atl_pkg::ALPHA_W-1:0] WEIGHT_TOP      = 17'd131071;
  localparam int ITEMS_PER_PHASE = 115;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES     = 120;

  typedef enum int {
    PRESS_NONE,
    PRESS_HOLD,
    PRESS_DRAIN
  } pressure_e;

  // Angle model: CORDIC tilt, smoothing filter and queue of pending tilts
  class tilt_scoreboard;
    logic [atl_pkg::ALPHA_W-1:0] weight;
    int                          kept_x;
    int                          kept_z;
    atl_pkg::atl_out_t           pending_tilts[$];
    int                          mismatches;

    function new();
      weight      = WEIGHT_AT_RESET;
      kept_x      = 0;
      kept_z      = 0;
      mismatches  = 0;
    endfunction

    // atan(2^-i) in centidegrees Q16
    function longint atan_step(int i);
      case (i)
        0: return 294912000;   1: return 174096719;   2: return 91987925;
        3: return 46694507;    4: return 23437865;    5: return 11730358;
        6: return 5866610;     7: return 2933484;     8: return 1466764;
        9: return 733385;      10: return 366693;     11: return 183346;
        12: return 91673;      13: return 45837;      14: return 22918;
        15: return 11459;      16: return 5730;       17: return 2865;
        18: return 1432;       19: return 716;        20: return 358;
        21: return 179;        22: return 90;         default: return 45;
      endcase
    endfunction

    // Rotate toward the x axis, accumulate the angle, then double and clamp it
    function longint tilt_target(logic signed [SAMPLE_WIDTH-1:0] reading);
      longint x, y, z, dx, dy;
      int     steps;
      x = longint'(ONE_G_COUNTS) <<< ANGLE_PRESCALE;
      y = reading;
      y = y <<< ANGLE_PRESCALE;
      z = 0;
      steps = (ATAN_ITERATIONS > ATAN_STEPS_MAX) ? ATAN_STEPS_MAX : ATAN_ITERATIONS;
      for (int i = 0; i < steps; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x = x + dx;
          y = y - dy;
          z = z + atan_step(i);
        end else begin
          x = x - dx;
          y = y + dy;
          z = z - atan_step(i);
        end
      end
      z = z * 2;
      if (z > TILT_LIMIT) z = TILT_LIMIT;
      if (z < -TILT_LIMIT) z = -TILT_LIMIT;
      return z;
    endfunction

    // Move the kept angle toward the target by the weight, floor rounding
    function int blend(int old, longint target);
      longint a, r;
      a = (weight > WEIGHT_FULL) ? longint'(WEIGHT_FULL) : longint'(weight);
      r = longint'(old) + (((target - longint'(old)) * a) >>> 16);
      return int'(r);
    endfunction

    // Drop the fraction, truncating toward zero
    function logic signed [atl_pkg::TILT_W-1:0] centideg(int q);
      longint v, c;
      v = q;
      if (v < 0) c = -((-v) >>> 16);
      else c = v >>> 16;
      return c[atl_pkg::TILT_W-1:0];
    endfunction

    function void note_sample(atl_pkg::atl_in_t sample);
      atl_pkg::atl_out_t want;
      kept_x = blend(kept_x, tilt_target(sample.accel_x));
      kept_z = blend(kept_z, -tilt_target(sample.accel_y));
      want.tilt_x = centideg(kept_x);
      want.tilt_z = centideg(kept_z);
      pending_tilts.push_back(want);
    endfunction

    function void check_tilt(atl_pkg::atl_out_t got);
      atl_pkg::atl_out_t want;
      if (pending_tilts.size() == 0) begin
        $display("%0t unexpected result: expected none, actual tilt_x %0d tilt_z %0d",
                 $time, got.tilt_x, got.tilt_z);
        mismatches++;
        return;
      end
      want = pending_tilts.pop_front();
      if (got.tilt_x !== want.tilt_x) begin
        $display("%0t tilt_x mismatch: expected %0d, actual %0d",
                 $time, want.tilt_x, got.tilt_x);
        mismatches++;
      end
      if (got.tilt_z !== want.tilt_z) begin
        $display("%0t tilt_z mismatch: expected %0d, actual %0d",
                 $time, want.tilt_z, got.tilt_z);
        mismatches++;
      end
    endfunction
  endclass

  logic                        clk_i;
  logic                        rst_ni;
  logic                        in_valid_i;
  logic                        in_stall_o;
  atl_pkg::atl_in_t            in_data_i;
  logic                        out_valid_o;
  logic                        out_stall_i;
  atl_pkg::atl_out_t           out_data_o;
  logic                        cfg_valid_i;
  logic                        cfg_ready_o;
  logic [atl_pkg::ALPHA_W-1:0] cfg_data_i;

  tilt_scoreboard sb = new();
  bit idle_on;
  bit hold_req;
  int last_x;
  int last_y;

  accel_tilt_lowpass_core #(
    .ONE_G_COUNTS    (ONE_G_COUNTS),
    .SAMPLE_WIDTH    (SAMPLE_WIDTH),
    .ATAN_ITERATIONS (ATAN_ITERATIONS)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Give up after a generous bound
  initial begin
    #5_000_000;
    $display("FAIL accel_tilt_lowpass_core");
    $finish;
  end

  // Track accepted samples and results
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      sb.note_sample(in_data_i);
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_tilt(out_data_o);
    end
  end

  // Stall the result side: short random bursts, or one long hold on request
  initial begin
    int hold_left;
    int burst_left;
    hold_left = 0;
    burst_left = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = LONG_HOLD_CYCLES - 1;
        out_stall_i <= 1'b1;
      end else if (idle_on && burst_left > 0) begin
        burst_left--;
        out_stall_i <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        burst_left = $urandom_range(0, 2);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Offer one sample, maybe after a short gap, and hold it until taken
  task automatic send_item(input logic signed [15:0] ax, input logic signed [15:0] ay);
    atl_pkg::atl_in_t sample;
    sample.accel_x = ax;
    sample.accel_y = ay;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= sample;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Wait until every pending tilt has come back
  task automatic wait_drain();
    @(posedge clk_i);
    while (sb.pending_tilts.size() != 0) @(posedge clk_i);
  endtask

  // Write the smoothing weight once the block is idle
  task automatic write_weight(input logic [atl_pkg::ALPHA_W-1:0] value);
    in_valid_i <= 1'b0;
    wait_drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.weight = value;
  endtask

  // Mostly smooth motion, with jumps, full-range noise and extremes
  function automatic logic signed [15:0] next_reading(int prev);
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = prev + int'($urandom_range(0, 1024)) - 512;
      4, 5:       v = int'($urandom_range(0, 16384)) - 8192;
      6, 7:       v = int'($signed($urandom() & 32'hFFFF)) - 32768;
      8: begin
        case ($urandom_range(0, 5))
          0: v = -32768;
          1: v = 32767;
          2: v = 0;
          3: v = -1;
          4: v = ONE_G_COUNTS;
          default: v = -ONE_G_COUNTS;
        endcase
      end
      default: v = int'($urandom_range(0, 32)) - 16;
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  task automatic run_phase(input logic [atl_pkg::ALPHA_W-1:0] weight, input bit idle,
                           input pressure_e pressure);
    logic signed [15:0] rx;
    logic signed [15:0] ry;
    idle_on = idle;
    write_weight(weight);
    for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
      if (pressure == PRESS_HOLD && i == 3) hold_req = 1'b1;
      if (pressure == PRESS_DRAIN && i == ITEMS_PER_PHASE / 2) begin
        in_valid_i <= 1'b0;
        wait_drain();
      end
      rx = next_reading(last_x);
      ry = next_reading(last_y);
      last_x = rx;
      last_y = ry;
      send_item(rx, ry);
    end
  endtask

  initial begin
    idle_on = 1'b1;
    hold_req = 1'b0;
    last_x = 0;
    last_y = 0;
    in_valid_i <= 1'b0;
    in_data_i <= '0;
    cfg_valid_i <= 1'b0;
    cfg_data_i <= '0;
    rst_ni <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Weight from reset
    send_item(16'sd0, 16'sd0);
    send_item(16'sd4096, -16'sd4096);
    send_item(16'sd32767, -16'sd32768);

    // Full weight: kept angle equals the target, so extremes show directly
    write_weight(WEIGHT_FULL);
    send_item(16'sd0, 16'sd0);
    send_item(16'sd4096, 16'sd4096);
    send_item(-16'sd4096, -16'sd4096);
    send_item(16'sd32767, 16'sd32767);
    send_item(-16'sd32768, -16'sd32768);
    send_item(16'sd1, -16'sd1);
    send_item(-16'sd1, 16'sd1);
    send_item(16'sd4095, -16'sd4095);
    send_item(16'sd8192, -16'sd12288);
    send_item(16'sh5555, 16'shAAAA);

    // Weight above one acts as one
    write_weight(WEIGHT_TOP);
    send_item(16'sd2048, -16'sd2048);
    send_item(-16'sd32768, 16'sd32767);

    // Zero weight: kept angles hold
    write_weight('0);
    send_item(16'sd32767, -16'sd32768);
    send_item(16'sd100, 16'sd200);

    // Smallest nonzero weight
    write_weight(17'd1);
    send_item(16'sd32767, -16'sd32768);
    send_item(-16'sd32768, 16'sd32767);

    // Random phases across weights; quiet last phase
    run_phase(WEIGHT_FULL, 1'b1, PRESS_NONE);
    run_phase(17'($urandom_range(1, 65535)), 1'b1, PRESS_HOLD);
    run_phase(WEIGHT_TOP, 1'b1, PRESS_NONE);
    run_phase('0, 1'b1, PRESS_NONE);
    run_phase(17'd32768, 1'b1, PRESS_DRAIN);
    run_phase(17'($urandom_range(65537, 131071)), 1'b0, PRESS_NONE);
    run_phase(WEIGHT_AT_RESET, 1'b1, PRESS_NONE);
    run_phase(17'($urandom_range(0, 65536)), 1'b0, PRESS_NONE);

    in_valid_i <= 1'b0;
    wait_drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_tilts.size() == 0) begin
      $display("PASS accel_tilt_lowpass_core");
    end else begin
      $display("FAIL accel_tilt_lowpass_core");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/atl_pkg.sv
rtl/core/atl_cordic.sv
rtl/core/atl_blend.sv
rtl/core/accel_tilt_lowpass_core.sv
test/accel_tilt_lowpass_core_test.sv
